### hw/rtl/bmhq_pkg.sv
// Shared types, codes and helpers for the binary min-heap queue.
`default_nettype none

package bmhq_pkg;

  // Operation codes carried on the input word
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_PEEK   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Configuration register map
  localparam logic REG_CAPACITY_LIMIT = 1'b0;
  localparam logic [8:0] CAP_LIMIT_RST = 9'd256;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_LAST,
    ST_REM_RD,
    ST_REM_CMP,
    ST_DONE
  } state_t;

  // One finished result handed to the output stage
  typedef struct packed {
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [8:0]         entry_count;
    logic [1:0]         status;
  } res_t;

  // Signed greater-than on two heap words
  function automatic logic gt_word(input logic signed [31:0] a, input logic signed [31:0] b);
    return a > b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bmhq_cfg.sv
// APB-style configuration register holding the capacity limit.
`default_nettype none

module bmhq_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic [8:0]       cap_limit
);
  import bmhq_pkg::*;

  logic [8:0] limit_r;
  logic [8:0] limit_nxt;
  logic       wr_en;

  // Decode a completed write to the limit register
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_CAPACITY_LIMIT);

  always_comb begin
    limit_nxt = limit_r;
    if (wr_en) begin
      limit_nxt = cfg_pwdata[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CAP_LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Return the register on reads, zero elsewhere
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == REG_CAPACITY_LIMIT) begin
      cfg_prdata = {23'd0, limit_r};
    end
  end

  assign cap_limit = limit_r;

endmodule

`default_nettype wire

### hw/rtl/bmhq_mem.sv
// Heap store: one write port, two registered read ports.
`default_nettype none

module bmhq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic signed [31:0]   wdata,
  input  wire logic [AW-1:0]        raddr_a,
  input  wire logic [AW-1:0]        raddr_b,
  output logic signed [31:0]        rdata_a,
  output logic signed [31:0]        rdata_b
);

  logic signed [31:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register both read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### hw/rtl/bmhq_ctrl.sv
// Sequencer for insert, remove and peek, with sift-up and sift-down over the store.
`default_nettype none

module bmhq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_value,
  input  wire logic [8:0]         cap_limit,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output bmhq_pkg::res_t          res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic signed [31:0]      mem_wdata,
  output logic [AW-1:0]           mem_raddr_a,
  output logic [AW-1:0]           mem_raddr_b,
  input  wire logic signed [31:0] mem_rdata_a,
  input  wire logic signed [31:0] mem_rdata_b
);
  import bmhq_pkg::*;

  localparam int LIMW = (CW > 9) ? CW : 9;
  localparam int LW   = AW + 1;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               rok_r, rok_nxt;
  logic signed [31:0] root_r, root_nxt;

  logic [LIMW-1:0]    eff_limit;
  logic               full;
  logic [AW-1:0]      parent;
  logic [LW-1:0]      left_idx;
  logic [LW-1:0]      right_idx;
  logic               pick_right;
  logic signed [31:0] pick_val;
  logic [LW-1:0]      pick_idx;

  // Effective limit is the smaller of the register and the built depth
  always_comb begin
    if (LIMW'(cap_limit) > LIMW'(CAPACITY)) begin
      eff_limit = LIMW'(CAPACITY);
    end else begin
      eff_limit = LIMW'(cap_limit);
    end
  end
  assign full = (LIMW'(cnt_r) >= eff_limit);

  // Tree addressing around the current position
  assign parent     = AW'((pos_r - 1'b1) >> 1);
  assign left_idx   = {pos_r, 1'b1};
  assign right_idx  = left_idx + 1'b1;
  assign pick_right = rok_r && gt_word(mem_rdata_a, mem_rdata_b);
  assign pick_val   = pick_right ? mem_rdata_b : mem_rdata_a;
  assign pick_idx   = pick_right ? right_idx : left_idx;

  // Next state, memory requests and datapath updates
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    stat_nxt    = stat_r;
    rok_nxt     = rok_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = val_r;
    mem_raddr_a = parent;
    mem_raddr_b = parent;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_INSERT: begin
              if (full) begin
                stat_nxt  = STAT_FULL;
                state_nxt = ST_DONE;
              end else begin
                stat_nxt  = STAT_OK;
                val_nxt   = in_value;
                pos_nxt   = AW'(cnt_r);
                state_nxt = ST_INS_RD;
              end
            end
            FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = ST_DONE;
              end else begin
                stat_nxt    = STAT_OK;
                mem_raddr_a = AW'(cnt_r - 1'b1);
                state_nxt   = ST_REM_LAST;
              end
            end
            default: begin
              stat_nxt  = (cnt_r == '0) ? STAT_EMPTY : STAT_OK;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_DONE;
        end else begin
          mem_raddr_a = parent;
          state_nxt   = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (gt_word(mem_rdata_a, val_r)) begin
          // Pull the larger parent down and climb
          mem_wdata = mem_rdata_a;
          pos_nxt   = parent;
          state_nxt = ST_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_REM_LAST: begin
        val_nxt = mem_rdata_a;
        cnt_nxt = cnt_r - 1'b1;
        pos_nxt = '0;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_REM_RD;
        end
      end
      ST_REM_RD: begin
        if (left_idx >= LW'(cnt_r)) begin
          mem_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          mem_raddr_a = left_idx[AW-1:0];
          mem_raddr_b = right_idx[AW-1:0];
          rok_nxt     = (right_idx < LW'(cnt_r));
          state_nxt   = ST_REM_CMP;
        end
      end
      ST_REM_CMP: begin
        mem_we = 1'b1;
        if (gt_word(val_r, pick_val)) begin
          // Lift the smaller child and descend
          mem_wdata = pick_val;
          pos_nxt   = pick_idx[AW-1:0];
          state_nxt = ST_REM_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Shadow the root entry for the result word
  always_comb begin
    root_nxt = root_r;
    if (mem_we && (mem_waddr == '0)) begin
      root_nxt = mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    stat_r <= stat_nxt;
    rok_r  <= rok_nxt;
    root_r <= root_nxt;
  end

  // Assemble the result
  always_comb begin
    res.top_valid   = (cnt_r != '0);
    res.top_value   = (cnt_r != '0) ? root_r : 32'sd0;
    res.entry_count = 9'(cnt_r);
    res.status      = stat_r;
  end

endmodule

`default_nettype wire

### hw/rtl/binary_min_heap_queue_core.sv
// Top level of the binary min-heap priority queue.
//
//  channel   dir  handshake                    word
//  in_       in   in_tvalid / in_tready        tuser: func, tdata: value
//  out_      out  out_tvalid / out_tready      tdata: top_value, entry_count; tuser: top_valid, status
//  cfg_      in   psel / penable / pready      capacity_limit at byte 0
//
// One word at a time: a peek or a refused word goes straight to the result; an insert
// compares one parent per level, a remove first fetches the last entry (and ends there
// when it takes the last entry) and then compares one child pair per level; each level is
// one read then one compare-and-write on the heap store.
// Reset clears the count and the state machine; the store is not swept, and only
// entries below the count are used. A stalled out_ holds the finished word in the output
// register while the next in_ word is already taken.
`default_nettype none

module binary_min_heap_queue_core #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] top_value, [40:32] entry_count, zero pad
  output logic [2:0]       out_tuser,  // [0] top_valid, [2:1] status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [8:0]         cap_limit;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr_a;
  logic [AW-1:0]      mem_raddr_b;
  logic signed [31:0] mem_rdata_a;
  logic signed [31:0] mem_rdata_b;

  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        out_data_r, out_data_nxt;
  logic [2:0]         out_user_r, out_user_nxt;

  bmhq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cap_limit   (cap_limit)
  );

  bmhq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .in_value    (in_tdata),
    .cap_limit   (cap_limit),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, res.entry_count, res.top_value};
      out_user_nxt  = {res.status, res.top_valid};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // An empty queue reports a zero top value
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[31:0] == 32'd0))
    else $error("empty queue reported nonzero top value");

  // A refused insert only happens with entries present, unless the limit is zero
  a_full_has_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] == STAT_FULL) && (cap_limit != 9'd0)) |-> out_tuser[0])
    else $error("full status without a stored entry");

  // An empty status comes with an empty queue
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] == STAT_EMPTY)) |-> !out_tuser[0])
    else $error("empty status while entries are stored");

  // Input is taken only while no result is being formed
  a_no_take_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("input taken while a result is pending");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the binary min-heap priority queue core.
`timescale 1ns / 1ps

module testbench;
  import bmhq_pkg::*;

  localparam int          HEAP_DEPTH     = 256;
  localparam logic [1:0]  FUNC_SPARE     = 2'd3;
  localparam logic [2:0]  CAP_LIMIT_ADDR = 3'(REG_CAPACITY_LIMIT) << 2;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 30;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] value
  logic [1:0]  in_tuser;    // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // [31:0] top_value, [40:32] entry_count, zero pad
  logic [2:0]  out_tuser;   // [0] top_valid, [2:1] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted heap contents, fill level and capacity limit
  int          heap_mem [HEAP_DEPTH];
  int unsigned heap_count;
  logic [8:0]  limit_reg;

  res_t        expected_tops[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          calm;

  binary_min_heap_queue_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the predicted heap and return the result word
  function automatic res_t heap_step(input logic [1:0] f, input int v);
    res_t        r;
    int unsigned lim;
    int unsigned pos;
    int unsigned parent;
    int unsigned n;
    int unsigned left;
    int unsigned pick;
    int          last;
    r.status = STAT_OK;
    lim = (limit_reg > HEAP_DEPTH) ? HEAP_DEPTH : limit_reg;
    if (f == FUNC_INSERT) begin
      if (heap_count >= lim || heap_count >= HEAP_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        // sift the new value up past larger parents
        pos = heap_count;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[parent] <= v) break;
          heap_mem[pos] = heap_mem[parent];
          pos = parent;
        end
        heap_mem[pos] = v;
        heap_count++;
      end
    end else if (f == FUNC_REMOVE) begin
      if (heap_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        // move the last entry to the root and sift it down
        n = heap_count - 1;
        last = heap_mem[n];
        heap_count = n;
        pos = 0;
        if (n > 0) begin
          forever begin
            left = 2 * pos + 1;
            if (left >= n) break;
            pick = left;
            // on equal children keep the left one
            if (left + 1 < n && heap_mem[left] > heap_mem[left + 1]) pick = left + 1;
            if (last <= heap_mem[pick]) break;
            heap_mem[pos] = heap_mem[pick];
            pos = pick;
          end
          heap_mem[pos] = last;
        end
      end
    end else if (heap_count == 0) begin
      // peek and the spare code both report an empty queue
      r.status = STAT_EMPTY;
    end
    r.top_value   = (heap_count > 0) ? heap_mem[0] : 0;
    r.top_valid   = (heap_count > 0);
    r.entry_count = 9'(heap_count);
    return r;
  endfunction

  // Send one word; idle at random first, hold valid across back-to-back words
  task automatic send_word(input logic [1:0] f, input logic [31:0] v);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_tops.push_back(heap_step(f, v));
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_tops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity limit, then read it back
  task automatic cfg_write_limit(input logic [8:0] lim);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CAP_LIMIT_ADDR;
    cfg_pwdata  <= 32'(lim);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    limit_reg = lim;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== 32'(lim)) begin
      $error("capacity_limit readback: expected %0d, actual %0d", lim, cfg_prdata);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mixed traffic; narrow values pile up duplicates for tie cases
  task automatic run_mix(input int unsigned items, input int unsigned ins_pct,
                         input int unsigned rem_pct, input bit narrow);
    int unsigned roll;
    logic [1:0]  f;
    logic [31:0] v;
    for (int unsigned i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) f = FUNC_INSERT;
      else if (roll < ins_pct + rem_pct) f = FUNC_REMOVE;
      else f = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : FUNC_PEEK;
      v = narrow ? 32'($urandom_range(0, 8)) - 32'd4 : $urandom;
      send_word(f, v);
    end
  endtask

  task automatic test_empty_queue();
    send_word(FUNC_PEEK, 32'h0);
    send_word(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_word(FUNC_SPARE, 32'h1234_5678);
    wait_drained();
  endtask

  task automatic test_value_extremes();
    send_word(FUNC_INSERT, 32'h7FFF_FFFF);
    send_word(FUNC_INSERT, 32'h8000_0000);
    send_word(FUNC_INSERT, 32'h0000_0000);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 32'h0000_0001);
    send_word(FUNC_PEEK, 32'hA5A5_A5A5);
    send_word(FUNC_SPARE, 32'h5A5A_5A5A);
    repeat (5) send_word(FUNC_REMOVE, 32'h0);
    wait_drained();
  endtask

  task automatic test_equal_children();
    send_word(FUNC_INSERT, 32'd1);
    send_word(FUNC_INSERT, 32'd3);
    send_word(FUNC_INSERT, 32'd3);
    send_word(FUNC_INSERT, 32'd9);
    // the last entry drops to the root and meets two equal children
    send_word(FUNC_REMOVE, 32'd0);
    wait_drained();
  endtask

  task automatic test_limit_edges();
    cfg_write_limit(9'd1);
    send_word(FUNC_INSERT, 32'd7);
    send_word(FUNC_INSERT, 32'd8);
    // the queue still holds entries from before; drop them
    repeat (3) send_word(FUNC_REMOVE, 32'd0);
    wait_drained();
    cfg_write_limit(9'd0);
    send_word(FUNC_INSERT, 32'd11);
    send_word(FUNC_PEEK, 32'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    // fill deep at the reset limit
    cfg_write_limit(9'd256);
    run_mix(400, 75, 15, 1'b0);
    wait_drained();
    // limit above the built size; run into full without any idling
    cfg_write_limit(9'd511);
    calm = 1'b1;
    run_mix(300, 85, 10, 1'b1);
    wait_drained();
    calm = 1'b0;
    // lower the limit below the fill level and drain through it
    cfg_write_limit(9'd100);
    run_mix(300, 30, 60, 1'b0);
    wait_drained();
    cfg_write_limit(9'($urandom_range(2, 16)));
    run_mix(300, 50, 40, 1'b1);
    wait_drained();
    cfg_write_limit(9'd0);
    run_mix(100, 40, 50, 1'b0);
    wait_drained();
    cfg_write_limit(9'd1);
    run_mix(100, 50, 35, 1'b0);
    wait_drained();
    cfg_write_limit(9'd256);
    run_mix(200, 45, 45, 1'b0);
    wait_drained();
  endtask

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin : check_word
      res_t want;
      if (expected_tops.size() == 0) begin
        $error("unexpected result word: top_value %0d, entry_count %0d",
               $signed(out_tdata[31:0]), out_tdata[40:32]);
        error_count++;
      end else begin
        want = expected_tops.pop_front();
        if (out_tdata[31:0] !== want.top_value) begin
          $error("top_value: expected %0d, actual %0d",
                 want.top_value, $signed(out_tdata[31:0]));
          error_count++;
        end
        if (out_tuser[0] !== want.top_valid) begin
          $error("top_valid: expected %0d, actual %0d", want.top_valid, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[40:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, out_tdata[40:32]);
          error_count++;
        end
        if (out_tuser[2:1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser[2:1]);
          error_count++;
        end
      end
    end
    out_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    heap_count  = 0;
    limit_reg   = CAP_LIMIT_RST;
    error_count = 0;
    calm        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_value_extremes();
    test_equal_children();
    test_limit_edges();
    test_random_traffic();

    if (error_count == 0 && expected_tops.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
